@@ src/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the poroelastic coupling stress pipeline.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int C_W       = PROD_W + 2;
    localparam int M_W       = PROD_W + 1;
    localparam int DET_W     = DATA_W + M_W;
    localparam int A_W       = 2 * C_W - 2;
    localparam int AL_W      = C_W;
    localparam int NUM_W     = A_W + DATA_W;
    localparam int DEN_W     = DET_W + FRAC_W;

    localparam int LIMB_W    = 32;
    localparam int PP_W      = 2 * LIMB_W;
    localparam int MOP_W     = C_W + 2;
    localparam int MUL_LIMBS = (MOP_W + LIMB_W - 1) / LIMB_W;
    localparam int LIMB_SPAN = MUL_LIMBS * LIMB_W;
    localparam int MP_W      = 2 * MOP_W;

    localparam int MUL_LAT   = 5;
    localparam int DIV_LAT   = DATA_W + 3;
    localparam int LANES     = 6;

    localparam logic [DATA_W:0]          SAT_MAG = (DATA_W + 1)'(1) << (DATA_W - 1);
    localparam logic [DATA_W-1:0]        MAX_POS = {1'b0, {(DATA_W - 1){1'b1}}};

    // output lanes in the order xx, yy, zz, yx, zy, zx
    localparam int LANE_XX = 0;
    localparam int LANE_YY = 1;
    localparam int LANE_ZZ = 2;
    localparam int LANE_YX = 3;
    localparam int LANE_ZY = 4;
    localparam int LANE_ZX = 5;

    // entries of C = F^T F
    localparam int C00 = 0;
    localparam int C11 = 1;
    localparam int C22 = 2;
    localparam int C01 = 3;
    localparam int C02 = 4;
    localparam int C12 = 5;

    localparam int C_ROW [6] = '{0, 1, 2, 0, 0, 1};
    localparam int C_COL [6] = '{0, 1, 2, 1, 2, 2};

    // adj(C) lane = X1*X2 - Y1*Y2
    localparam int ADJ_X1 [6] = '{C11, C00, C00, C02, C01, C01};
    localparam int ADJ_X2 [6] = '{C22, C22, C11, C12, C02, C12};
    localparam int ADJ_Y1 [6] = '{C12, C02, C01, C01, C00, C02};
    localparam int ADJ_Y2 [6] = '{C12, C02, C01, C22, C12, C11};

    typedef struct packed {
        logic signed [DATA_W-1:0] f_xx;
        logic signed [DATA_W-1:0] f_xy;
        logic signed [DATA_W-1:0] f_xz;
        logic signed [DATA_W-1:0] f_yx;
        logic signed [DATA_W-1:0] f_yy;
        logic signed [DATA_W-1:0] f_yz;
        logic signed [DATA_W-1:0] f_zx;
        logic signed [DATA_W-1:0] f_zy;
        logic signed [DATA_W-1:0] f_zz;
        logic signed [DATA_W-1:0] pressure;
    } pcs_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] stress_xx;
        logic signed [DATA_W-1:0] stress_yy;
        logic signed [DATA_W-1:0] stress_zz;
        logic signed [DATA_W-1:0] stress_yx;
        logic signed [DATA_W-1:0] stress_zy;
        logic signed [DATA_W-1:0] stress_zx;
        logic                     singular;
    } pcs_out_t;

    typedef struct packed {
        logic                     valid;
        logic                     plane;
        logic signed [DATA_W-1:0] pressure;
        logic signed [M_W-1:0]    det2;
        logic signed [C_W-1:0]    c00;
        logic signed [C_W-1:0]    c11;
        logic signed [C_W-1:0]    c01;
    } pcs_sbc_t;

    typedef struct packed {
        logic                    valid;
        logic                    plane;
        logic                    singular;
        logic signed [DEN_W-1:0] den;
    } pcs_sbf_t;

    typedef struct packed {
        logic valid;
        logic plane;
        logic singular;
    } pcs_sbq_t;

endpackage

@@ src/pcs_mul.sv @@
// ----------------------------------------------------------------------------
// pcs_mul
// Pipelined signed multiplier built from 32x32 limb products, five stages.
// ----------------------------------------------------------------------------
module pcs_mul (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [pcs_pkg::MOP_W-1:0] a,
    input  logic signed [pcs_pkg::MOP_W-1:0] b,
    output logic signed [pcs_pkg::MP_W-1:0]  p
);
    import pcs_pkg::*;

    logic [MOP_W-1:0]     a_mag_reg;
    logic [MOP_W-1:0]     b_mag_reg;
    logic [LIMB_SPAN-1:0] a_ext;
    logic [LIMB_SPAN-1:0] b_ext;
    logic [PP_W-1:0]      pp_reg [MUL_LIMBS][MUL_LIMBS];
    logic [MP_W-1:0]      row_next [MUL_LIMBS];
    logic [MP_W-1:0]      row_reg [MUL_LIMBS];
    logic [MP_W-1:0]      sum_next;
    logic [MP_W-1:0]      sum_reg;
    logic [MP_W-1:0]      p_reg;
    logic                 neg1_reg;
    logic                 neg2_reg;
    logic                 neg3_reg;
    logic                 neg4_reg;

    always_comb begin
        a_ext = LIMB_SPAN'(a_mag_reg);
        b_ext = LIMB_SPAN'(b_mag_reg);
        for (int i = 0; i < MUL_LIMBS; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < MUL_LIMBS; j++) begin
                row_next[i] = row_next[i] + (MP_W'(pp_reg[i][j]) << (j * LIMB_W));
            end
        end
        sum_next = '0;
        for (int i = 0; i < MUL_LIMBS; i++) begin
            sum_next = sum_next + (row_reg[i] << (i * LIMB_W));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg <= a[MOP_W-1] ? (~a + 1'b1) : a;
            b_mag_reg <= b[MOP_W-1] ? (~b + 1'b1) : b;
            neg1_reg  <= a[MOP_W-1] ^ b[MOP_W-1];
            for (int i = 0; i < MUL_LIMBS; i++) begin
                for (int j = 0; j < MUL_LIMBS; j++) begin
                    pp_reg[i][j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
                end
            end
            neg2_reg <= neg1_reg;
            row_reg  <= row_next;
            neg3_reg <= neg2_reg;
            sum_reg  <= sum_next;
            neg4_reg <= neg3_reg;
            p_reg    <= neg4_reg ? (~sum_reg + 1'b1) : sum_reg;
        end
    end

    assign p = $signed(p_reg);

endmodule

@@ src/pcs_div.sv @@
// ----------------------------------------------------------------------------
// pcs_div
// Pipelined restoring divider, one quotient bit per stage, with round to
// nearest, saturation and sign.
// ----------------------------------------------------------------------------
module pcs_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [pcs_pkg::NUM_W-2:0]         nabs,
    input  logic [pcs_pkg::DEN_W-1:0]         dabs,
    input  logic                              neg,
    output logic signed [pcs_pkg::DATA_W-1:0] q
);
    import pcs_pkg::*;

    logic [DEN_W-1:0]  r_reg   [0:DATA_W];
    logic [DATA_W-1:0] lo_reg  [0:DATA_W];
    logic [DATA_W-1:0] q_reg   [0:DATA_W];
    logic [DEN_W-1:0]  d_reg   [0:DATA_W];
    logic              ovf_reg [0:DATA_W];
    logic              neg_reg [0:DATA_W];
    logic [DEN_W:0]    trial   [1:DATA_W];
    logic              ge      [1:DATA_W];
    logic [DEN_W:0]    diff    [1:DATA_W];
    logic              rnd_reg;
    logic [DATA_W-1:0] qf_reg;
    logic              ovf_f_reg;
    logic              neg_f_reg;
    logic [DATA_W:0]   qr;
    logic [DATA_W:0]   mag;
    logic [DATA_W-1:0] q_next;
    logic [DATA_W-1:0] q_out_reg;

    always_comb begin
        for (int k = 1; k <= DATA_W; k++) begin
            trial[k] = {r_reg[k-1], lo_reg[k-1][DATA_W-1]};
            ge[k]    = trial[k] >= {1'b0, d_reg[k-1]};
            diff[k]  = trial[k] - {1'b0, d_reg[k-1]};
        end
    end

    always_comb begin
        qr  = {1'b0, qf_reg} + (DATA_W + 1)'(rnd_reg);
        mag = (ovf_f_reg || qr > SAT_MAG) ? SAT_MAG : qr;
        if (neg_f_reg) begin
            q_next = ~mag[DATA_W-1:0] + 1'b1;
        end else if (ovf_f_reg || qr >= SAT_MAG) begin
            q_next = MAX_POS;
        end else begin
            q_next = qr[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= nabs[DEN_W+DATA_W-1:DATA_W];
            lo_reg[0]  <= nabs[DATA_W-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= dabs;
            ovf_reg[0] <= nabs[NUM_W-2:DATA_W] >= (NUM_W - 1 - DATA_W)'(dabs);
            neg_reg[0] <= neg;
            for (int k = 1; k <= DATA_W; k++) begin
                r_reg[k]   <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
                lo_reg[k]  <= {lo_reg[k-1][DATA_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][DATA_W-2:0], ge[k]};
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            rnd_reg   <= {r_reg[DATA_W], 1'b0} >= {1'b0, d_reg[DATA_W]};
            qf_reg    <= q_reg[DATA_W];
            ovf_f_reg <= ovf_reg[DATA_W];
            neg_f_reg <= neg_reg[DATA_W];
            q_out_reg <= q_next;
        end
    end

    assign q = $signed(q_out_reg);

endmodule

@@ src/poro_coupling_stress_unit.sv @@
// ----------------------------------------------------------------------------
// poro_coupling_stress_unit
// Poroelastic coupling stress S = -p adj(F^T F) / det F in signed fixed point.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while its skid entry is empty and
// returns one result per request, in order. The path runs through two
// five-stage limb multipliers (for adj(C) and det F, then for the pressure
// product) and the restoring divider that produces each stress lane. All
// six lanes divide in parallel. A two-entry output buffer lets the pipe
// keep taking requests while a result waits. plane_mode is sampled with
// each request and must be written only while the unit is empty.
module poro_coupling_stress_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pcs_pkg::pcs_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pcs_pkg::pcs_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);
    import pcs_pkg::*;

    logic en;
    logic plane_reg;

    // stage a
    logic signed [DATA_W-1:0] fm [3][3];
    logic signed [DATA_W-1:0] fc [3][3];
    logic                     a_valid_reg;
    logic                     a_plane_reg;
    logic signed [DATA_W-1:0] a_p_reg;
    logic signed [DATA_W-1:0] a_f0_reg [3];
    logic signed [PROD_W-1:0] cp_reg [6][3];
    logic signed [PROD_W-1:0] mp_reg [6];
    logic signed [PROD_W-1:0] dp_reg [2];

    // stage b
    logic                     b_valid_reg;
    logic                     b_plane_reg;
    logic signed [DATA_W-1:0] b_p_reg;
    logic signed [DATA_W-1:0] b_f0_reg [3];
    logic signed [C_W-1:0]    c_reg [6];
    logic signed [M_W-1:0]    m_reg [3];
    logic signed [M_W-1:0]    d2_reg;

    // multiplier outputs
    logic signed [MP_W-1:0]   adj_x_p [LANES];
    logic signed [MP_W-1:0]   adj_y_p [LANES];
    logic signed [MP_W-1:0]   det_p [3];
    logic signed [MP_W-1:0]   ph [LANES];
    logic signed [MP_W-1:0]   pl [LANES];

    pcs_sbc_t                 sbc_next;
    pcs_sbc_t                 sbc_reg [MUL_LAT];

    // stage d
    pcs_sbc_t                 sbd_reg;
    logic signed [A_W-1:0]    adj3_reg [LANES];
    logic signed [DET_W-1:0]  det3_reg;

    // stage e
    logic signed [DET_W-1:0]  det_sel;
    logic signed [A_W-1:0]    a_sel [LANES];
    logic signed [DEN_W-1:0]  den_sel;
    logic signed [A_W-1:0]    e_a_reg [LANES];
    logic signed [DATA_W-1:0] e_p_reg;
    pcs_sbf_t                 e_sb_reg;
    pcs_sbf_t                 sbf_reg [MUL_LAT];

    // stage g
    logic signed [NUM_W-1:0]  num_reg [LANES];
    logic [DEN_W-1:0]         g_dabs_reg;
    logic                     g_dneg_reg;
    pcs_sbq_t                 sbg_reg;
    logic signed [DEN_W-1:0]  den_last;

    // stage h
    logic [NUM_W-1:0]         num_mag [LANES];
    logic [NUM_W-2:0]         nabs_reg [LANES];
    logic                     h_neg_reg [LANES];
    logic [DEN_W-1:0]         h_dabs_reg;
    pcs_sbq_t                 sbh_reg;

    logic signed [DATA_W-1:0] q_div [LANES];
    pcs_sbq_t                 sbq_reg [DIV_LAT];

    // output side
    logic                     pipe_valid;
    logic signed [DATA_W-1:0] lane_out [LANES];
    pcs_out_t                 out_next;
    pcs_out_t                 m_data_reg;
    pcs_out_t                 skid_data_reg;
    logic                     m_valid_reg;
    logic                     skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            plane_reg <= cfg_wr_data;
        end
    end

    // stage a: 32x32 products
    always_comb begin
        fm[0][0] = s_data.f_xx;
        fm[0][1] = s_data.f_xy;
        fm[0][2] = s_data.f_xz;
        fm[1][0] = s_data.f_yx;
        fm[1][1] = s_data.f_yy;
        fm[1][2] = s_data.f_yz;
        fm[2][0] = s_data.f_zx;
        fm[2][1] = s_data.f_zy;
        fm[2][2] = s_data.f_zz;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                fc[i][j] = (plane_reg && i == 2) ? '0 : fm[i][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int e = 0; e < 6; e++) begin
                for (int k = 0; k < 3; k++) begin
                    cp_reg[e][k] <= fc[k][C_ROW[e]] * fc[k][C_COL[e]];
                end
            end
            mp_reg[0] <= fm[1][1] * fm[2][2];
            mp_reg[1] <= fm[1][2] * fm[2][1];
            mp_reg[2] <= fm[1][0] * fm[2][2];
            mp_reg[3] <= fm[1][2] * fm[2][0];
            mp_reg[4] <= fm[1][0] * fm[2][1];
            mp_reg[5] <= fm[1][1] * fm[2][0];
            dp_reg[0] <= fm[0][0] * fm[1][1];
            dp_reg[1] <= fm[0][1] * fm[1][0];
            for (int j = 0; j < 3; j++) begin
                a_f0_reg[j] <= fm[0][j];
            end
            a_p_reg     <= s_data.pressure;
            a_plane_reg <= plane_reg;

            // stage b: sums
            for (int e = 0; e < 6; e++) begin
                c_reg[e] <= C_W'(cp_reg[e][0]) + C_W'(cp_reg[e][1]) + C_W'(cp_reg[e][2]);
            end
            m_reg[0] <= M_W'(mp_reg[0]) - M_W'(mp_reg[1]);
            m_reg[1] <= M_W'(mp_reg[2]) - M_W'(mp_reg[3]);
            m_reg[2] <= M_W'(mp_reg[4]) - M_W'(mp_reg[5]);
            d2_reg   <= M_W'(dp_reg[0]) - M_W'(dp_reg[1]);
            b_f0_reg <= a_f0_reg;
            b_p_reg     <= a_p_reg;
            b_plane_reg <= a_plane_reg;
        end
    end

    // adj(C) and det F products
    for (genvar g = 0; g < LANES; g++) begin : g_adj
        pcs_mul u_mul_x (
            .aclk (aclk),
            .en   (en),
            .a    (MOP_W'(c_reg[ADJ_X1[g]])),
            .b    (MOP_W'(c_reg[ADJ_X2[g]])),
            .p    (adj_x_p[g])
        );
        pcs_mul u_mul_y (
            .aclk (aclk),
            .en   (en),
            .a    (MOP_W'(c_reg[ADJ_Y1[g]])),
            .b    (MOP_W'(c_reg[ADJ_Y2[g]])),
            .p    (adj_y_p[g])
        );
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        pcs_mul u_mul_det (
            .aclk (aclk),
            .en   (en),
            .a    (MOP_W'(b_f0_reg[j])),
            .b    (MOP_W'(m_reg[j])),
            .p    (det_p[j])
        );
    end

    always_comb begin
        sbc_next.valid    = b_valid_reg;
        sbc_next.plane    = b_plane_reg;
        sbc_next.pressure = b_p_reg;
        sbc_next.det2     = d2_reg;
        sbc_next.c00      = c_reg[C00];
        sbc_next.c11      = c_reg[C11];
        sbc_next.c01      = c_reg[C01];
    end

    // stage e: mode selection
    always_comb begin
        det_sel = sbd_reg.plane ? DET_W'(sbd_reg.det2) : det3_reg;
        for (int g = 0; g < LANES; g++) begin
            a_sel[g] = sbd_reg.plane ? '0 : adj3_reg[g];
        end
        if (sbd_reg.plane) begin
            a_sel[LANE_XX] = A_W'(sbd_reg.c11);
            a_sel[LANE_YY] = A_W'(sbd_reg.c00);
            a_sel[LANE_YX] = -A_W'(sbd_reg.c01);
        end
        den_sel = sbd_reg.plane ? DEN_W'(det_sel) : (DEN_W'(det_sel) <<< FRAC_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUL_LAT; i++) begin
                sbc_reg[i].valid <= 1'b0;
                sbf_reg[i].valid <= 1'b0;
            end
            sbd_reg.valid  <= 1'b0;
            e_sb_reg.valid <= 1'b0;
            sbg_reg.valid  <= 1'b0;
            sbh_reg.valid  <= 1'b0;
        end else if (en) begin
            sbc_reg[0] <= sbc_next;
            sbf_reg[0] <= e_sb_reg;
            for (int i = 1; i < MUL_LAT; i++) begin
                sbc_reg[i] <= sbc_reg[i-1];
                sbf_reg[i] <= sbf_reg[i-1];
            end
            sbd_reg           <= sbc_reg[MUL_LAT-1];
            e_sb_reg.valid    <= sbd_reg.valid;
            e_sb_reg.plane    <= sbd_reg.plane;
            e_sb_reg.singular <= det_sel == '0;
            e_sb_reg.den      <= den_sel;
            sbg_reg.valid     <= sbf_reg[MUL_LAT-1].valid;
            sbg_reg.plane     <= sbf_reg[MUL_LAT-1].plane;
            sbg_reg.singular  <= sbf_reg[MUL_LAT-1].singular;
            sbh_reg           <= sbg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < LANES; g++) begin
                adj3_reg[g] <= A_W'(adj_x_p[g] - adj_y_p[g]);
            end
            det3_reg <= DET_W'(det_p[0] - det_p[1] + det_p[2]);
            e_a_reg  <= a_sel;
            e_p_reg  <= sbd_reg.pressure;
        end
    end

    // pressure products, split into high and low parts of adj
    for (genvar g = 0; g < LANES; g++) begin : g_num
        pcs_mul u_mul_hi (
            .aclk (aclk),
            .en   (en),
            .a    (MOP_W'(e_p_reg)),
            .b    (MOP_W'($signed(e_a_reg[g][A_W-1:AL_W]))),
            .p    (ph[g])
        );
        pcs_mul u_mul_lo (
            .aclk (aclk),
            .en   (en),
            .a    (MOP_W'(e_p_reg)),
            .b    (MOP_W'({1'b0, e_a_reg[g][AL_W-1:0]})),
            .p    (pl[g])
        );
    end

    assign den_last = sbf_reg[MUL_LAT-1].den;

    always_comb begin
        for (int g = 0; g < LANES; g++) begin
            num_mag[g] = num_reg[g][NUM_W-1] ? (~num_reg[g] + 1'b1) : num_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < LANES; g++) begin
                num_reg[g] <= $signed({ph[g][NUM_W-AL_W-1:0], AL_W'(0)}) + NUM_W'(pl[g]);
                nabs_reg[g]  <= num_mag[g][NUM_W-2:0];
                h_neg_reg[g] <= num_reg[g][NUM_W-1] == g_dneg_reg;
            end
            g_dabs_reg <= den_last[DEN_W-1] ? (~den_last + 1'b1) : den_last;
            g_dneg_reg <= den_last[DEN_W-1];
            h_dabs_reg <= g_dabs_reg;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_div
        pcs_div u_div (
            .aclk (aclk),
            .en   (en),
            .nabs (nabs_reg[g]),
            .dabs (h_dabs_reg),
            .neg  (h_neg_reg[g]),
            .q    (q_div[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                sbq_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            sbq_reg[0] <= sbh_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                sbq_reg[i] <= sbq_reg[i-1];
            end
        end
    end

    // zero forcing for singular and unused plane lanes
    always_comb begin
        pipe_valid = sbq_reg[DIV_LAT-1].valid;
        for (int g = 0; g < LANES; g++) begin
            if (sbq_reg[DIV_LAT-1].singular) begin
                lane_out[g] = '0;
            end else if (sbq_reg[DIV_LAT-1].plane &&
                         (g == LANE_ZZ || g == LANE_ZY || g == LANE_ZX)) begin
                lane_out[g] = '0;
            end else begin
                lane_out[g] = q_div[g];
            end
        end
        out_next.stress_xx = lane_out[LANE_XX];
        out_next.stress_yy = lane_out[LANE_YY];
        out_next.stress_zz = lane_out[LANE_ZZ];
        out_next.stress_yx = lane_out[LANE_YX];
        out_next.stress_zy = lane_out[LANE_ZY];
        out_next.stress_zx = lane_out[LANE_ZX];
        out_next.singular  = sbq_reg[DIV_LAT-1].singular;
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else if (en && pipe_valid) begin
                m_data_reg <= out_next;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg) begin
            if (en && pipe_valid) begin
                m_data_reg  <= out_next;
                m_valid_reg <= 1'b1;
            end
        end else if (en && pipe_valid) begin
            skid_data_reg  <= out_next;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/pcs_checker.sv @@
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the coupling stress unit, bound to the top level.
// ----------------------------------------------------------------------------
module pcs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input pcs_pkg::pcs_out_t m_data,
    input logic              cfg_wr_en,
    input logic              cfg_wr_data
);
    import pcs_pkg::*;

    logic plane_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_seen_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            plane_seen_reg <= cfg_wr_data;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // singular results carry no stress
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.singular |->
            m_data.stress_xx == '0 && m_data.stress_yy == '0 &&
            m_data.stress_zz == '0 && m_data.stress_yx == '0 &&
            m_data.stress_zy == '0 && m_data.stress_zx == '0)
        else $error("nonzero stress on singular result");

    // plane mode leaves out-of-plane lanes at zero
    a_plane_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && plane_seen_reg |->
            m_data.stress_zz == '0 && m_data.stress_zy == '0 &&
            m_data.stress_zx == '0)
        else $error("out-of-plane stress in plane mode");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind poro_coupling_stress_unit pcs_checker u_pcs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);

@@ sim/poro_coupling_stress_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poro_coupling_stress_unit_test
// Self-checking bench for the coupling stress unit. Requests go in over a
// valid/ready channel. A scoreboard predicts S = -p adj(F^T F) / det F with
// exact wide integers in both 3D and plane mode, and compares each result in
// order. Both sides idle at random, and the result side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module poro_coupling_stress_unit_test;
    import pcs_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam logic [31:0] Q_ONE    = 32'h0001_0000;
    localparam int          SETTLE   = 60;
    localparam int          WDOG_LIM = 20000;

    class stress_scoreboard;
        pcs_out_t pending_q[$];
        int       errors;
        int       checked;
        int       singular_seen;

        function automatic logic [31:0] div_round_sat(wide_t num, wide_t den);
            wide_t n, d, q, r, lim;
            bit    neg;
            neg = (num < 0) != (den < 0);
            n   = (num < 0) ? -num : num;
            d   = (den < 0) ? -den : den;
            q   = n / d;
            r   = n % d;
            if ((r <<< 1) >= d) q = q + 1;
            lim = wide_t'(1) <<< (DATA_W - 1);
            if (neg) begin
                if (q > lim) q = lim;
                q = -q;
            end else if (q >= lim) begin
                q = lim - 1;
            end
            return q[31:0];
        endfunction

        function void note(pcs_in_t x, bit plane);
            wide_t    fm[3][3];
            wide_t    cm[3][3];
            wide_t    adj[6];
            wide_t    p, det, den;
            pcs_out_t res;
            int       n;
            fm[0][0] = x.f_xx; fm[0][1] = x.f_xy; fm[0][2] = x.f_xz;
            fm[1][0] = x.f_yx; fm[1][1] = x.f_yy; fm[1][2] = x.f_yz;
            fm[2][0] = x.f_zx; fm[2][1] = x.f_zy; fm[2][2] = x.f_zz;
            p = x.pressure;
            n = plane ? 2 : 3;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    cm[i][j] = 0;
                    for (int k = 0; k < n; k++)
                        cm[i][j] += fm[k][i] * fm[k][j];
                end
            for (int i = 0; i < 6; i++) adj[i] = 0;
            if (plane) begin
                det    = fm[0][0] * fm[1][1] - fm[0][1] * fm[1][0];
                den    = det;
                adj[0] = cm[1][1];
                adj[1] = cm[0][0];
                adj[3] = -cm[0][1];
            end else begin
                det = fm[0][0] * (fm[1][1] * fm[2][2] - fm[1][2] * fm[2][1])
                    - fm[0][1] * (fm[1][0] * fm[2][2] - fm[1][2] * fm[2][0])
                    + fm[0][2] * (fm[1][0] * fm[2][1] - fm[1][1] * fm[2][0]);
                den    = det <<< FRAC_W;
                adj[0] = cm[1][1] * cm[2][2] - cm[1][2] * cm[1][2];
                adj[1] = cm[0][0] * cm[2][2] - cm[0][2] * cm[0][2];
                adj[2] = cm[0][0] * cm[1][1] - cm[0][1] * cm[0][1];
                adj[3] = cm[0][2] * cm[1][2] - cm[0][1] * cm[2][2];
                adj[4] = cm[0][1] * cm[0][2] - cm[0][0] * cm[1][2];
                adj[5] = cm[0][1] * cm[1][2] - cm[0][2] * cm[1][1];
            end
            res = '0;
            if (det == 0) begin
                res.singular = 1'b1;
            end else begin
                res.stress_xx = div_round_sat(-(p * adj[0]), den);
                res.stress_yy = div_round_sat(-(p * adj[1]), den);
                res.stress_yx = div_round_sat(-(p * adj[3]), den);
                if (!plane) begin
                    res.stress_zz = div_round_sat(-(p * adj[2]), den);
                    res.stress_zy = div_round_sat(-(p * adj[4]), den);
                    res.stress_zx = div_round_sat(-(p * adj[5]), den);
                end
            end
            pending_q = {pending_q, res};
        endfunction

        function void check(pcs_out_t got);
            pcs_out_t    want;
            logic [31:0] w[7];
            logic [31:0] g[7];
            string       names[7];
            names = '{"stress_xx", "stress_yy", "stress_zz", "stress_yx",
                      "stress_zy", "stress_zx", "singular"};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.singular) singular_seen++;
            w = '{want.stress_xx, want.stress_yy, want.stress_zz, want.stress_yx,
                  want.stress_zy, want.stress_zx, 32'(want.singular)};
            g = '{got.stress_xx, got.stress_yy, got.stress_zz, got.stress_yx,
                  got.stress_zy, got.stress_zx, 32'(got.singular)};
            for (int i = 0; i < 7; i++)
                if (w[i] !== g[i]) begin
                    $display("%0t: %s mismatch expected %h actual %h",
                             $time, names[i], w[i], g[i]);
                    errors++;
                end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pcs_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pcs_out_t m_data;
    logic     cfg_wr_en = 1'b0;
    logic     cfg_wr_data = 1'b0;

    stress_scoreboard sb = new();
    bit  plane_cfg = 1'b0;
    bit  calm = 1'b0;
    bit  hold_done = 1'b0;
    bit  feeding = 1'b0;
    int  idle_cycles = 0;
    int  sent = 0;

    poro_coupling_stress_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // request and result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) plane_cfg <= cfg_wr_data;
            if (s_valid && s_ready) sb.note(s_data, plane_cfg);
            if (m_valid && m_ready) sb.check(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIM) begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side, with one long hold-off while requests keep coming
    initial begin
        int held;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && feeding && sent > 300) begin
                m_ready = 1'b0;
                for (held = 0; held < 400; held++) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_ready = (calm || $urandom_range(99) >= 34);
        end
    end

    task automatic write_plane(bit v);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic send_item(pcs_in_t x);
        while (!calm && $urandom_range(99) < 34) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = x;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [31:0] near_val(bit diag);
        logic [31:0] v;
        v = $urandom_range(0, 32767) - 16384;
        return diag ? v + Q_ONE : v;
    endfunction

    function automatic pcs_in_t rand_item();
        pcs_in_t x;
        int      kind;
        kind = $urandom_range(9);
        x = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 5) begin
            x.f_xx = near_val(1); x.f_xy = near_val(0); x.f_xz = near_val(0);
            x.f_yx = near_val(0); x.f_yy = near_val(1); x.f_yz = near_val(0);
            x.f_zx = near_val(0); x.f_zy = near_val(0); x.f_zz = near_val(1);
            x.pressure = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        end else if (kind == 5) begin
            // rank deficient: second row copies the first
            x.f_yx = x.f_xx; x.f_yy = x.f_xy; x.f_yz = x.f_xz;
        end else if (kind == 6) begin
            // tiny entries push results into saturation
            x.f_xx = $urandom_range(0, 15) - 8; x.f_yy = $urandom_range(0, 15) - 8;
            x.f_zz = $urandom_range(0, 15) - 8; x.f_xy = $urandom_range(0, 3);
            x.f_xz = 0; x.f_yx = 0; x.f_yz = 0; x.f_zx = 0; x.f_zy = 0;
        end
        return x;
    endfunction

    task automatic run_directed();
        pcs_in_t x;
        x = '0;
        send_item(x);
        x.f_xx = Q_ONE; x.f_yy = Q_ONE; x.f_zz = Q_ONE; x.pressure = Q_ONE;
        send_item(x);
        x.pressure = 32'hFFFF_0000;
        send_item(x);
        x = {10{32'h7FFF_FFFF}};
        send_item(x);
        x = {10{32'h8000_0000}};
        send_item(x);
        x = '0;
        x.f_xx = 32'h7FFF_FFFF; x.f_yy = 32'h8000_0000; x.f_zz = 32'h7FFF_FFFF;
        x.f_xy = 32'h8000_0000; x.pressure = 32'h7FFF_FFFF;
        send_item(x);
        x = '0;
        x.f_xx = 1; x.f_yy = 1; x.f_zz = 1; x.pressure = 32'h8000_0000;
        send_item(x);
        // rounding ties
        x = '0;
        x.f_xx = 2; x.f_yy = 1; x.f_zz = 32'h0000_8000; x.pressure = 2;
        send_item(x);
        x.f_zz = 32'hFFFF_8000;
        send_item(x);
        x = '0;
        x.f_xx = 2; x.f_yy = 1; x.pressure = 1;
        send_item(x);
        x.pressure = 32'hFFFF_FFFF;
        send_item(x);
        x = '0;
        x.f_xx = Q_ONE; x.f_xy = Q_ONE; x.f_yx = Q_ONE; x.f_yy = Q_ONE;
        x.f_zz = Q_ONE; x.pressure = Q_ONE;
        send_item(x);
        x.f_zz = 32'h0003_0000; x.f_xz = 32'h1234_5678; x.f_zx = 32'hDEAD_BEEF;
        send_item(x);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 3 && i < count / 3 + 150);
            send_item(rand_item());
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        write_plane(1'b0);
        run_directed();
        drain();
        write_plane(1'b1);
        run_directed();
        drain();
        feeding = 1'b1;
        run_random(700);
        drain();
        write_plane(1'b0);
        run_random(800);
        drain();
        write_plane(1'b1);
        run_random(250);
        drain();
        $display("checked %0d results (%0d singular) over %0d requests",
                 sb.checked, sb.singular_seen, sent);
        $display("covered 3D and plane mode, extremes, ties, and a long result stall");
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/pcs_pkg.sv
src/pcs_mul.sv
src/pcs_div.sv
src/poro_coupling_stress_unit.sv
src/pcs_checker.sv
sim/poro_coupling_stress_unit_test.sv
